// ----- src/cts_pkg.sv -----
// Shared constants, command and status types, and the month length table.
package cts_pkg;

  localparam logic [11:0] EpochYear    = 12'd1970;
  localparam logic [6:0]  EpochMod100  = 7'd70;   // 1970 mod 100
  localparam logic [8:0]  EpochMod400  = 9'd370;  // 1970 mod 400
  localparam logic [31:0] DaySec       = 32'd86400;
  localparam logic [31:0] HourSec      = 32'd3600;
  localparam logic [31:0] MinSec       = 32'd60;
  localparam logic [31:0] OffsetReset  = 32'd32400;
  localparam logic [31:0] LongYearDays = 32'd366;
  localparam logic [31:0] YearDays     = 32'd365;

  // Reciprocals for dividing by 60 and by 24
  localparam logic [31:0] Rcp60 = 32'h8888_8889;   // shift 37, exact for any 32-bit value
  localparam logic [31:0] Rcp24 = 32'd178956971;   // shift 32, exact below 2^29
  localparam logic [31:0] Div60 = 32'd60;
  localparam logic [31:0] Div24 = 32'd24;

  // Year divided by 25: (year * Rcp25) >> 16, exact for 12-bit years
  localparam logic [11:0] Rcp25 = 12'd2622;
  localparam logic [7:0]  Div25 = 8'd25;

  // Digit selects for the time-of-day breakdown
  localparam logic [1:0] DigitSec  = 2'd0;
  localparam logic [1:0] DigitMin  = 2'd1;
  localparam logic [1:0] DigitHour = 2'd2;

  typedef struct packed {
    logic       load;
    logic       yin_step;
    logic       min_step;
    logic       day_add;
    logic       mul;
    logic       shift;
    logic       divq;
    logic       divr;
    logic       yout_step;
    logic       mout_step;
    logic       publish;
    logic [1:0] digit;
  } cmd_t;

  typedef struct packed {
    logic yin_more;
    logic min_more;
    logic yout_more;
    logic mout_hit;
    logic slot_free;
  } sts_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] mon, input logic leap);
    logic [4:0] d;
    case (mon) inside
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2:                    d = leap ? 5'd29 : 5'd28;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- src/calendar_time_shift_converter_unit.sv -----
// Top level of the calendar time shift converter.
//
// Usage:
//   Input channel (in_valid / in_stall): one item is a UTC calendar time
//   (year, month, day, hour, minute, second). It is taken at an edge where
//   in_valid is high and in_stall is low. in_stall stays high from the edge
//   after an item is taken until its result sits in the output register.
//   Output channel (out_valid / out_stall): one result per item, holding the
//   unshifted seconds since 1970 and the calendar time of that count plus
//   the signed offset register, modulo 2^32.
//   Configuration: cfg_we writes cfg_wdata into the offset register at the
//   edge; write only while no item is in flight.
// Steps: a year walk up to in_year adds one year length per step and a
//   month walk adds one month length per step; the day and the time of
//   day are added and the offset is applied; the three divides by 60, 60
//   and 24, each a quotient step and then a remainder step, share one
//   reciprocal multiplier; a year walk and a month walk then take the
//   shifted days apart, subtracting one year or month length per step.
//   The input opens at the edge that loads the result, so no new item is
//   taken before its predecessor's result is in the output register.
// Reset: rst is synchronous; it clears the sequencer and the output valid and
//   loads the offset with UTC plus 9 hours (32400 s).
// Stall: a result held by out_stall stays in the output register; the next
//   item is still taken and worked through, then waits at the final step until
//   the output register frees.
module calendar_time_shift_converter_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic signed [31:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        in_year,
  input  logic [3:0]         in_month,
  input  logic [4:0]         in_day,
  input  logic [4:0]         in_hour,
  input  logic [5:0]         in_minute,
  input  logic [5:0]         in_second,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        epoch_seconds,
  output logic [11:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_second
);

  cts_pkg::cmd_t cmd;
  cts_pkg::sts_t sts;

  // Sequencer: walks one item through the steps
  cts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: holds the item, the offset and the output register
  cts_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .in_hour       (in_hour),
    .in_minute     (in_minute),
    .in_second     (in_second),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .epoch_seconds (epoch_seconds),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .out_hour      (out_hour),
    .out_minute    (out_minute),
    .out_second    (out_second)
  );

  // A taken item blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not blocked after an item was taken");

  // A fresh result comes with the input open again
  a_open_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result published while the sequencer is still busy");

  // Every published month and time of day is in range, and the day is not zero
  a_result_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12) && (out_day >= 5'd1) &&
                  (out_hour < 5'd24) && (out_minute < 6'd60) && (out_second < 6'd60))
    else $error("published calendar field out of range");

endmodule

// ----- src/cts_ctrl.sv -----
// Sequencer that steps one item through the calendar walks and the time-of-day breakdown.
module cts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  cts_pkg::sts_t sts,
  output cts_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_YEAR_IN  = 11'b000_0000_0010,
    ST_MON_IN   = 11'b000_0000_0100,
    ST_DAY_IN   = 11'b000_0000_1000,
    ST_MUL      = 11'b000_0001_0000,
    ST_SHIFT    = 11'b000_0010_0000,
    ST_DIV_Q    = 11'b000_0100_0000,
    ST_DIV_R    = 11'b000_1000_0000,
    ST_YEAR_OUT = 11'b001_0000_0000,
    ST_MON_OUT  = 11'b010_0000_0000,
    ST_FINISH   = 11'b100_0000_0000
  } state_t;

  state_t     state, state_next;
  logic [1:0] digit, digit_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      digit <= cts_pkg::DigitSec;
    end else begin
      state <= state_next;
      digit <= digit_next;
    end
  end

  always_comb begin
    state_next = state;
    digit_next = digit;
    cmd        = '0;
    cmd.digit  = digit;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_YEAR_IN;
        end
      end
      ST_YEAR_IN: begin
        if (sts.yin_more) begin
          cmd.yin_step = 1'b1;
        end else begin
          state_next = ST_MON_IN;
        end
      end
      ST_MON_IN: begin
        if (sts.min_more) begin
          cmd.min_step = 1'b1;
        end else begin
          state_next = ST_DAY_IN;
        end
      end
      ST_DAY_IN: begin
        cmd.day_add = 1'b1;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        digit_next = cts_pkg::DigitSec;
        state_next = ST_DIV_Q;
      end
      ST_DIV_Q: begin
        cmd.divq   = 1'b1;
        state_next = ST_DIV_R;
      end
      ST_DIV_R: begin
        cmd.divr = 1'b1;
        if (digit == cts_pkg::DigitHour) begin
          state_next = ST_YEAR_OUT;
        end else begin
          digit_next = digit + 2'd1;
          state_next = ST_DIV_Q;
        end
      end
      ST_YEAR_OUT: begin
        if (sts.yout_more) begin
          cmd.yout_step = 1'b1;
        end else begin
          state_next = ST_MON_OUT;
        end
      end
      ST_MON_OUT: begin
        cmd.mout_step = 1'b1;
        if (sts.mout_hit) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts.slot_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- src/cts_dp.sv -----
// Datapath: day accumulator, year counters, constant divider, offset register and result stage.
module cts_dp (
  input  logic                clk,
  input  logic                rst,
  input  cts_pkg::cmd_t       cmd,
  output cts_pkg::sts_t       sts,
  input  logic                cfg_we,
  input  logic signed [31:0]  cfg_wdata,
  input  logic [11:0]         in_year,
  input  logic [3:0]          in_month,
  input  logic [4:0]          in_day,
  input  logic [4:0]          in_hour,
  input  logic [5:0]          in_minute,
  input  logic [5:0]          in_second,
  input  logic                out_stall,
  output logic                out_valid,
  output logic [31:0]         epoch_seconds,
  output logic [11:0]         out_year,
  output logic [3:0]          out_month,
  output logic [4:0]          out_day,
  output logic [4:0]          out_hour,
  output logic [5:0]          out_minute,
  output logic [5:0]          out_second
);

  // Held input item
  logic [11:0] yr_q;
  logic [3:0]  mo_q;
  logic [4:0]  dy_q;
  logic [4:0]  hr_q;
  logic [5:0]  mi_q;
  logic [5:0]  se_q;
  logic [7:0]  q25;

  // Walk state
  logic [31:0] days;
  logic [11:0] year_cnt;
  logic [6:0]  mod100;
  logic [8:0]  mod400;
  logic [3:0]  mon;

  // Arithmetic
  logic [31:0] epoch;
  logic [31:0] xval;
  logic [31:0] quo;

  // Working result
  logic [5:0]  res_sec;
  logic [5:0]  res_min;
  logic [4:0]  res_hour;
  logic [3:0]  res_mon;
  logic [4:0]  res_day;

  logic signed [31:0] offset;

  logic [23:0] q25_prod;
  logic [12:0] yr_back;
  logic        leap_in;
  logic        leap_cnt;
  logic [31:0] year_len;
  logic [4:0]  dim_in;
  logic [4:0]  dim_cnt;
  logic [31:0] hms;
  logic [31:0] mul_lo;
  logic [31:0] rcp;
  logic [31:0] dv;
  logic [63:0] prod;
  logic [31:0] quo_next;
  logic [31:0] rem_full;
  logic        day_fits;
  logic [11:0] year_adv;
  logic [6:0]  mod100_adv;
  logic [8:0]  mod400_adv;

  // Leap test of the held input year through a divide by 25
  assign q25_prod = in_year * cts_pkg::Rcp25;
  assign yr_back  = q25 * cts_pkg::Div25;
  assign leap_in  = (yr_q[1:0] == 2'd0) &&
                    ((yr_back != {1'b0, yr_q}) || (yr_q[3:0] == 4'd0));

  // Leap test of the running year from its residues
  assign leap_cnt = (year_cnt[1:0] == 2'd0) && ((mod100 != 7'd0) || (mod400 == 9'd0));
  assign year_len = leap_cnt ? cts_pkg::LongYearDays : cts_pkg::YearDays;

  assign dim_in  = cts_pkg::days_in_month(mon, leap_in);
  assign dim_cnt = cts_pkg::days_in_month(mon, leap_cnt);

  assign year_adv   = year_cnt + 12'd1;
  assign mod100_adv = (mod100 == 7'd99)  ? 7'd0 : mod100 + 7'd1;
  assign mod400_adv = (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;

  assign hms    = {27'd0, hr_q} * cts_pkg::HourSec + {26'd0, mi_q} * cts_pkg::MinSec
                  + {26'd0, se_q};
  assign mul_lo = days * cts_pkg::DaySec;

  assign rcp      = (cmd.digit == cts_pkg::DigitHour) ? cts_pkg::Rcp24 : cts_pkg::Rcp60;
  assign dv       = (cmd.digit == cts_pkg::DigitHour) ? cts_pkg::Div24 : cts_pkg::Div60;
  assign prod     = {32'd0, xval} * {32'd0, rcp};
  assign quo_next = (cmd.digit == cts_pkg::DigitHour) ? prod[63:32] : {5'd0, prod[63:37]};
  assign rem_full = xval - quo * dv;

  assign day_fits = (days < {27'd0, dim_cnt});

  assign sts.yin_more  = (year_cnt < yr_q);
  assign sts.min_more  = (mon < mo_q) && (mon <= 4'd12);
  assign sts.yout_more = (days >= year_len);
  assign sts.mout_hit  = day_fits || (mon == 4'd12);
  assign sts.slot_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      yr_q     <= in_year;
      mo_q     <= in_month;
      dy_q     <= in_day;
      hr_q     <= in_hour;
      mi_q     <= in_minute;
      se_q     <= in_second;
      q25      <= q25_prod[23:16];
      days     <= '0;
      year_cnt <= cts_pkg::EpochYear;
      mod100   <= cts_pkg::EpochMod100;
      mod400   <= cts_pkg::EpochMod400;
      mon      <= 4'd1;
    end
    if (cmd.yin_step) begin
      days     <= days + year_len;
      year_cnt <= year_adv;
      mod100   <= mod100_adv;
      mod400   <= mod400_adv;
    end
    if (cmd.min_step) begin
      days <= days + {27'd0, dim_in};
      mon  <= mon + 4'd1;
    end
    if (cmd.day_add) begin
      days <= days + {27'd0, dy_q} - 32'd1;
    end
    if (cmd.mul) begin
      epoch <= mul_lo + hms;
    end
    if (cmd.shift) begin
      xval <= epoch + $unsigned(offset);
    end
    if (cmd.divq) begin
      quo <= quo_next;
    end
    if (cmd.divr) begin
      xval <= quo;
      case (cmd.digit)
        cts_pkg::DigitSec: res_sec  <= rem_full[5:0];
        cts_pkg::DigitMin: res_min  <= rem_full[5:0];
        default:           res_hour <= rem_full[4:0];
      endcase
      if (cmd.digit == cts_pkg::DigitHour) begin
        days     <= quo;
        year_cnt <= cts_pkg::EpochYear;
        mod100   <= cts_pkg::EpochMod100;
        mod400   <= cts_pkg::EpochMod400;
        mon      <= 4'd1;
      end
    end
    if (cmd.yout_step) begin
      days     <= days - year_len;
      year_cnt <= year_adv;
      mod100   <= mod100_adv;
      mod400   <= mod400_adv;
    end
    if (cmd.mout_step) begin
      if (sts.mout_hit) begin
        res_mon <= mon;
        res_day <= day_fits ? (days[4:0] + 5'd1) : 5'd31;
      end else begin
        days <= days - {27'd0, dim_cnt};
        mon  <= mon + 4'd1;
      end
    end
    if (cmd.publish) begin
      epoch_seconds <= epoch;
      out_year      <= year_cnt;
      out_month     <= res_mon;
      out_day       <= res_day;
      out_hour      <= res_hour;
      out_minute    <= res_min;
      out_second    <= res_sec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      offset    <= $signed(cts_pkg::OffsetReset);
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cfg_we) begin
        offset <= cfg_wdata;
      end
    end
  end

endmodule

// ----- tb/sv/cts_conv_scoreboard_pkg.sv -----
// Date arithmetic and result scoreboard for the calendar time shift converter bench.
package cts_conv_scoreboard_pkg;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } civil_time_t;

  typedef struct packed {
    logic [31:0] epoch;
    civil_time_t shifted;
  } conversion_t;

  function automatic bit is_leap(int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(int unsigned m, int unsigned y);
    int unsigned len;
    case ((m - 1) % 12)
      3, 5, 8, 10: len = 30;
      1:           len = 28;
      default:     len = 31;
    endcase
    if (m == 2 && is_leap(y)) len = 29;
    return len;
  endfunction

  // Seconds since 1970; every term wraps at 32 bits.
  function automatic bit [31:0] calendar_to_epoch(civil_time_t t);
    bit [31:0] days;
    int unsigned y;
    int unsigned m;
    days = 0;
    for (y = 1970; y < t.year; y++) days += is_leap(y) ? 366 : 365;
    for (m = 1; m < t.month && m <= 12; m++) days += month_length(m, t.year);
    days += {27'd0, t.day} - 32'd1;
    return days * 32'd86400 + {27'd0, t.hour} * 32'd3600 + {26'd0, t.minute} * 32'd60
           + {26'd0, t.second};
  endfunction

  function automatic civil_time_t epoch_to_calendar(bit [31:0] ts);
    civil_time_t c;
    bit [31:0] rest;
    bit [31:0] days;
    bit [31:0] span;
    int unsigned y;
    int unsigned m;
    bit found;
    c.second = 6'(ts % 60);
    rest = ts / 60;
    c.minute = 6'(rest % 60);
    rest = rest / 60;
    c.hour = 5'(rest % 24);
    days = rest / 24;
    y = 1970;
    span = is_leap(y) ? 366 : 365;
    while (days >= span) begin
      days -= span;
      y++;
      span = is_leap(y) ? 366 : 365;
    end
    c.year = 12'(y);
    c.month = 4'd12;
    c.day = 5'd31;
    found = 1'b0;
    for (m = 1; m <= 12 && !found; m++) begin
      span = month_length(m, y);
      if (days < span) begin
        c.month = 4'(m);
        c.day = 5'(days + 1);
        found = 1'b1;
      end else begin
        days -= span;
      end
    end
    return c;
  endfunction

  class shift_conv_scoreboard;
    bit [31:0]   offset_reg;
    conversion_t pending_results[$];
    int unsigned results_checked;
    int unsigned errors;
    int unsigned reported;

    function new(bit [31:0] reset_offset);
      offset_reg = reset_offset;
      results_checked = 0;
      errors = 0;
      reported = 0;
    endfunction

    function void note_item(civil_time_t t);
      conversion_t r;
      r.epoch = calendar_to_epoch(t);
      r.shifted = epoch_to_calendar(r.epoch + offset_reg);
      pending_results.push_back(r);
    endfunction

    function void check_item(conversion_t got);
      conversion_t exp;
      if (pending_results.size() == 0) begin
        errors++;
        reported++;
        if (reported <= 10) $display("ERROR: unexpected result epoch=%0d", got.epoch);
        return;
      end
      exp = pending_results.pop_front();
      results_checked++;
      if (got.epoch !== exp.epoch || got.shifted.year !== exp.shifted.year ||
          got.shifted.month !== exp.shifted.month || got.shifted.day !== exp.shifted.day ||
          got.shifted.hour !== exp.shifted.hour || got.shifted.minute !== exp.shifted.minute ||
          got.shifted.second !== exp.shifted.second) begin
        errors++;
        reported++;
        if (reported <= 10) begin
          $display("ERROR: result %0d expected epoch=%0d %0d-%0d-%0d %0d:%0d:%0d",
                   results_checked, exp.epoch, exp.shifted.year, exp.shifted.month,
                   exp.shifted.day, exp.shifted.hour, exp.shifted.minute, exp.shifted.second);
          $display("       got      epoch=%0d %0d-%0d-%0d %0d:%0d:%0d",
                   got.epoch, got.shifted.year, got.shifted.month, got.shifted.day,
                   got.shifted.hour, got.shifted.minute, got.shifted.second);
        end
      end
    endfunction

    function void finish_check();
      if (pending_results.size() != 0) begin
        errors += pending_results.size();
        $display("ERROR: %0d results never arrived", pending_results.size());
      end
    endfunction
  endclass

endpackage

// ----- tb/sv/tb_calendar_time_shift_converter_unit.sv -----
// Top-level bench: drives calendar times and offsets into the converter and checks every result.
module tb_calendar_time_shift_converter_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // Long enough to cover one worst-case conversion (year 4095 walk) after the last result.
  localparam int SettleCycles  = 3000;
  localparam int HoldCycles    = 1500;
  localparam int ItemsPerPhase = 90;
  localparam int PhaseCount    = 6;

  typedef enum int {PaceSlowSink, PaceSlowSource, PaceSteady} pace_e;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic signed [31:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  logic [11:0]        in_year;
  logic [3:0]         in_month;
  logic [4:0]         in_day;
  logic [4:0]         in_hour;
  logic [5:0]         in_minute;
  logic [5:0]         in_second;
  logic               out_valid;
  logic               out_stall;
  logic [31:0]        epoch_seconds;
  logic [11:0]        out_year;
  logic [3:0]         out_month;
  logic [4:0]         out_day;
  logic [4:0]         out_hour;
  logic [5:0]         out_minute;
  logic [5:0]         out_second;

  cts_conv_scoreboard_pkg::shift_conv_scoreboard sb;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests;      // bumped by the stimulus to ask for one long receiver hold-off
  int holds_served;       // advanced by the receiver when it starts a hold-off
  int items_sent;
  int odd_items;          // items with year off 1970-2105, zero month or day, or a field too big
  int offsets_used;

  calendar_time_shift_converter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_year       (in_year),
    .in_month      (in_month),
    .in_day        (in_day),
    .in_hour       (in_hour),
    .in_minute     (in_minute),
    .in_second     (in_second),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds),
    .out_year      (out_year),
    .out_month     (out_month),
    .out_day       (out_day),
    .out_hour      (out_hour),
    .out_minute    (out_minute),
    .out_second    (out_second)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #100ms;
    $display("Verification failed");
    $finish;
  end

  // Receiver: stall at random per the current pace, or hold off for a long
  // counted stretch when the stimulus asks for one.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Result monitor: sample at the rising edge, before the block updates.
  always @(posedge clk) begin
    cts_conv_scoreboard_pkg::conversion_t got;
    if (!rst && out_valid && !out_stall) begin
      got.epoch          = epoch_seconds;
      got.shifted.year   = out_year;
      got.shifted.month  = out_month;
      got.shifted.day    = out_day;
      got.shifted.hour   = out_hour;
      got.shifted.minute = out_minute;
      got.shifted.second = out_second;
      sb.check_item(got);
    end
  end

  function automatic cts_conv_scoreboard_pkg::civil_time_t civil(int y, int mo, int d,
                                                                 int h, int mi, int s);
    cts_conv_scoreboard_pkg::civil_time_t t;
    t.year   = 12'(y);
    t.month  = 4'(mo);
    t.day    = 5'(d);
    t.hour   = 5'(h);
    t.minute = 6'(mi);
    t.second = 6'(s);
    return t;
  endfunction

  // Mostly real dates; some items carry arbitrary field values, and a few of
  // those use any 12-bit year (slow year walks, so keep them rare).
  function automatic cts_conv_scoreboard_pkg::civil_time_t random_time();
    cts_conv_scoreboard_pkg::civil_time_t t;
    int unsigned pick;
    pick = $urandom_range(99);
    t.year   = 12'($urandom_range(2105, 1970));
    t.month  = 4'($urandom_range(12, 1));
    t.day    = 5'($urandom_range(cts_conv_scoreboard_pkg::month_length(t.month, t.year), 1));
    t.hour   = 5'($urandom_range(23));
    t.minute = 6'($urandom_range(59));
    t.second = 6'($urandom_range(59));
    if (pick >= 85) begin
      t.month  = 4'($urandom);
      t.day    = 5'($urandom);
      t.hour   = 5'($urandom);
      t.minute = 6'($urandom);
      t.second = 6'($urandom);
      if (pick >= 95) t.year = 12'($urandom);
      else t.year = 12'($urandom_range(2200, 1900));
    end
    return t;
  endfunction

  // Offer one item at the falling edge, hold it until accepted, then log it.
  // Valid stays high on return so back-to-back items never drop it.
  task automatic send_time(input cts_conv_scoreboard_pkg::civil_time_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    {in_year, in_month, in_day, in_hour, in_minute, in_second} = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_item(t);
    items_sent++;
    if (t.year < 1970 || t.year > 2105 || t.month == 0 || t.month > 12 || t.day == 0 ||
        t.hour > 23 || t.minute > 59 || t.second > 59)
      odd_items++;
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has come back.
  task automatic wait_for_results();
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
  endtask

  // Change the offset only with the block drained and idle.
  task automatic write_offset(input logic [31:0] value);
    wait_for_results();
    repeat (4) @(negedge clk);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    sb.offset_reg = value;
    offsets_used++;
  endtask

  initial begin
    cts_conv_scoreboard_pkg::civil_time_t corner[$];
    logic [31:0] offsets[PhaseCount];
    pace_e pace;

    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    {in_year, in_month, in_day, in_hour, in_minute, in_second} = '0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests = 0;
    holds_served  = 0;
    items_sent    = 0;
    odd_items     = 0;
    offsets_used  = 1;   // reset value counts as the first setting
    sb = new(cts_pkg::OffsetReset);

    repeat (10) @(negedge clk);
    rst = 1'b0;

    // Directed corners under the reset offset.
    corner.push_back(civil(1970, 1, 1, 0, 0, 0));       // epoch zero
    corner.push_back(civil(2105, 12, 31, 23, 59, 59));  // last normal year
    corner.push_back(civil(2106, 2, 7, 6, 28, 15));     // all-ones count, shift wraps to 1970
    corner.push_back(civil(2000, 2, 29, 12, 0, 0));     // leap by the 400 rule
    corner.push_back(civil(2100, 2, 28, 23, 0, 0));     // century, not leap
    corner.push_back(civil(2100, 3, 1, 0, 0, 0));
    corner.push_back(civil(2024, 2, 29, 18, 30, 30));
    corner.push_back(civil(1999, 12, 31, 23, 59, 59));  // shift crosses a year
    corner.push_back(civil(2038, 1, 19, 3, 14, 7));
    corner.push_back(civil(1969, 7, 20, 20, 17, 40));   // year before 1970 adds no years
    corner.push_back(civil(0, 0, 0, 0, 0, 0));          // day zero wraps the count
    corner.push_back(civil(2023, 0, 15, 8, 0, 0));      // month zero acts as January
    corner.push_back(civil(2023, 13, 1, 0, 0, 0));      // month past December
    corner.push_back(civil(2024, 15, 31, 12, 0, 0));
    corner.push_back(civil(2020, 3, 0, 1, 2, 3));       // day zero
    corner.push_back(civil(2021, 4, 31, 10, 0, 0));     // day past month end
    corner.push_back(civil(2010, 6, 15, 31, 63, 63));   // hour, minute, second past range
    corner.push_back(civil(2048, 8, 16, 16, 32, 32));   // high bit of each field
    corner.push_back(civil(4095, 15, 31, 31, 63, 63));  // every input bit set
    corner.push_back(civil(1600, 6, 30, 7, 45, 1));
    foreach (corner[i]) send_time(corner[i]);

    // Offsets per random phase: zero, both extremes, minus nine hours, random, random negative.
    offsets[0] = 32'd0;
    offsets[1] = 32'h8000_0000;
    offsets[2] = 32'h7FFF_FFFF;
    offsets[3] = 32'hFFFF_8170;
    offsets[4] = $urandom;
    offsets[5] = 32'd0 - $urandom_range(1_000_000);

    for (int p = 0; p < PhaseCount; p++) begin
      write_offset(offsets[p]);
      pace = pace_e'(p / 2);
      case (pace)
        PaceSlowSink: begin
          send_idle_pct = 29;
          recv_idle_pct = 53;
        end
        PaceSlowSource: begin
          send_idle_pct = 53;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      // Back the receiver up for a long stretch while items keep coming,
      // so the output register fills and the input stalls.
      if (p == 1 || p == 4) hold_requests++;
      for (int i = 0; i < ItemsPerPhase; i++) begin
        if (i == ItemsPerPhase / 2) wait_for_results();
        send_time(random_time());
      end
    end

    wait_for_results();
    repeat (SettleCycles) @(negedge clk);
    sb.finish_check();

    $display("Run summary: %0d calendar times (%0d with out-of-range fields) over %0d offsets",
             items_sent, odd_items, offsets_used);
    $display("Run summary: %0d conversions checked, %0d errors", sb.results_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/cts_pkg.sv
src/cts_ctrl.sv
src/cts_dp.sv
src/calendar_time_shift_converter_unit.sv
tb/sv/cts_conv_scoreboard_pkg.sv
tb/sv/tb_calendar_time_shift_converter_unit.sv
